// ===== rtl/clbs_pkg.sv =====
// Shared types, codes and the initialisation table of the character display bus sequencer.
// Depends on nothing; the top level, the controller and the datapath import it.
package clbs_pkg;

  // Request codes carried in the operation field.
  localparam logic [1:0] OP_COMMAND = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_INIT    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_EIGHT_BIT  = 3'd0;
  localparam logic [2:0] REG_PULSE_US   = 3'd1;
  localparam logic [2:0] REG_CYCLE_US   = 3'd2;
  localparam logic [2:0] REG_COMMAND_US = 3'd3;
  localparam logic [2:0] REG_SLOW_MS    = 3'd4;
  localparam logic [2:0] REG_POWER_MS   = 3'd5;

  // Kind of pin state the controller asks for.
  localparam logic [1:0] KIND_POWER = 2'd0;
  localparam logic [1:0] KIND_HIGH  = 2'd1;
  localparam logic [1:0] KIND_LOW   = 2'd2;

  // Fixed waits added after an initialisation transfer.
  localparam logic [1:0] EXTRA_NONE  = 2'd0;
  localparam logic [1:0] EXTRA_LONG  = 2'd1;
  localparam logic [1:0] EXTRA_SHORT = 2'd2;

  localparam int HOLD_W = 18;

  localparam logic [7:0]  BYTE_CLEAR    = 8'h01;
  localparam logic [7:0]  BYTE_HOME     = 8'h02;
  localparam logic [7:0]  NIBBLE_MASK   = 8'hF0;
  localparam logic [9:0]  US_PER_MS     = 10'd1000;
  localparam logic [12:0] WAIT_LONG_US  = 13'd5000;
  localparam logic [12:0] WAIT_SHORT_US = 13'd150;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic [1:0] kind;
    logic       sel;
    logic [7:0] data;
    logic       add_cmd;
    logic [1:0] extra;
    logic       slow;
    logic       last;
  } clbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eight_bit;
    logic ready;
  } clbs_stat_t;

  // One transfer of a request: a byte, or a single upper nibble.
  typedef struct packed {
    logic [7:0] value;
    logic       nibble_only;
    logic [1:0] extra;
  } clbs_entry_t;

  // Transfers of the power-up sequence after the initial power wait.
  // The 4-bit sequence has eight transfers, the 8-bit one seven.
  function automatic clbs_entry_t init_entry(input logic eight_bit, input logic [2:0] idx);
    clbs_entry_t e;
    e = '{value: 8'h00, nibble_only: 1'b0, extra: EXTRA_NONE};
    case (idx)
      3'd0: e = '{value: 8'h30, nibble_only: ~eight_bit, extra: EXTRA_LONG};
      3'd1: e = '{value: 8'h30, nibble_only: ~eight_bit, extra: EXTRA_SHORT};
      3'd2: e = '{value: 8'h30, nibble_only: ~eight_bit, extra: EXTRA_SHORT};
      3'd3: begin
        if (eight_bit) begin
          e = '{value: 8'h38, nibble_only: 1'b0, extra: EXTRA_NONE};
        end else begin
          e = '{value: 8'h20, nibble_only: 1'b1, extra: EXTRA_NONE};
        end
      end
      3'd4: e.value = eight_bit ? 8'h0C : 8'h28;
      3'd5: e.value = eight_bit ? 8'h06 : 8'h0C;
      3'd6: e.value = eight_bit ? 8'h01 : 8'h06;
      3'd7: e.value = 8'h01;
      default: e.value = 8'h00;
    endcase
    return e;
  endfunction

endpackage

// ===== rtl/char_lcd_bus_sequencer_top.sv =====
// Character display bus sequencer, top level: a write or initialise request in,
// a run of pin states out. The request is registered in the controller, and its first pin state
// then in the output register. Throughput: one pin state per cycle while the output is taken;
// a byte is 4 states in 4-bit mode and 2 in 8-bit mode, initialisation is 25 or 15 states,
// and the next request is accepted once the controller has loaded the last state.
// Reset (synchronous, active low) empties the output and loads the register defaults.
module char_lcd_bus_sequencer_top import clbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // operation [1:0], value [9:2], zero [15:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // enable [0], data_lines [8:1], hold_us [26:9], zero [31:27]
  output logic        out_tuser,  // reg_select [0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  clbs_cmd_t         cmd;
  clbs_stat_t        stat;
  logic              enable;
  logic [7:0]        data_lines;
  logic [HOLD_W-1:0] hold_us;

  clbs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_operation (in_tdata[1:0]),
    .in_value     (in_tdata[9:2]),
    .stat         (stat),
    .cmd          (cmd)
  );

  clbs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_reg_select (out_tuser),
    .out_enable     (enable),
    .out_data_lines (data_lines),
    .out_hold_us    (hold_us),
    .out_last       (out_tlast)
  );

  // Pack the pin state, lowest field first.
  assign out_tdata = {5'd0, hold_us, data_lines, enable};

endmodule

// ===== rtl/clbs_ctrl.sv =====
// Controller of the bus sequencer: walks the transfers and pulses of one request.
// Depends on clbs_pkg.
module clbs_ctrl import clbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_value,
  input  clbs_stat_t stat,
  output clbs_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_POWER = 2'd1;
  localparam logic [1:0] ST_HIGH  = 2'd2;
  localparam logic [1:0] ST_LOW   = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [1:0] op_r, op_nxt;
  logic [7:0] value_r, value_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       phase_r, phase_nxt;

  clbs_entry_t entry;
  logic [2:0]  last_idx;
  logic        final_pulse;
  logic        final_entry;
  logic        sel;
  logic [7:0]  pulse_data;

  // Current transfer and where it stands in the request.
  always_comb begin
    if (op_r == OP_INIT) begin
      entry = init_entry(stat.eight_bit, idx_r);
    end else begin
      entry = '{value: value_r, nibble_only: 1'b0, extra: EXTRA_NONE};
    end
    last_idx    = stat.eight_bit ? 3'd6 : 3'd7;
    final_pulse = stat.eight_bit | entry.nibble_only | phase_r;
    final_entry = (op_r != OP_INIT) || (idx_r == last_idx);
    sel         = (op_r == OP_DATA);
    if (stat.eight_bit) begin
      pulse_data = entry.value;
    end else if (phase_r) begin
      pulse_data = {entry.value[3:0], 4'h0};
    end else begin
      pulse_data = entry.value & NIBBLE_MASK;
    end
  end

  // Command to the datapath for the pin state of the current step.
  always_comb begin
    cmd.load    = stat.ready && (st_r != ST_IDLE);
    cmd.sel     = sel;
    cmd.data    = pulse_data;
    cmd.add_cmd = 1'b0;
    cmd.extra   = EXTRA_NONE;
    cmd.slow    = 1'b0;
    cmd.last    = 1'b0;
    case (st_r)
      ST_POWER: begin
        cmd.kind = KIND_POWER;
        cmd.sel  = 1'b0;
        cmd.data = 8'h00;
      end
      ST_HIGH: begin
        cmd.kind = KIND_HIGH;
      end
      ST_LOW: begin
        cmd.kind    = KIND_LOW;
        cmd.add_cmd = final_pulse & ~entry.nibble_only;
        cmd.extra   = final_pulse ? entry.extra : EXTRA_NONE;
        cmd.slow    = final_pulse && !entry.nibble_only && !sel &&
                      (entry.value == BYTE_CLEAR || entry.value == BYTE_HOME);
        cmd.last    = final_pulse & final_entry;
      end
      default: begin
        cmd.kind = KIND_POWER;
      end
    endcase
  end

  assign in_ready = (st_r == ST_IDLE);

  // Step sequencing: one pin state each time the output register takes one.
  always_comb begin
    st_nxt    = st_r;
    op_nxt    = op_r;
    value_nxt = value_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          value_nxt = in_value;
          idx_nxt   = 3'd0;
          phase_nxt = 1'b0;
          case (in_operation)
            OP_INIT:    st_nxt = ST_POWER;
            OP_COMMAND: st_nxt = ST_HIGH;
            OP_DATA:    st_nxt = ST_HIGH;
            default:    st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POWER: begin
        if (stat.ready) begin
          st_nxt = ST_HIGH;
        end
      end
      ST_HIGH: begin
        if (stat.ready) begin
          st_nxt = ST_LOW;
        end
      end
      ST_LOW: begin
        if (stat.ready) begin
          if (!final_pulse) begin
            phase_nxt = 1'b1;
            st_nxt    = ST_HIGH;
          end else if (!final_entry) begin
            idx_nxt   = idx_r + 3'd1;
            phase_nxt = 1'b0;
            st_nxt    = ST_HIGH;
          end else begin
            st_nxt = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      op_r    <= OP_COMMAND;
      idx_r   <= 3'd0;
      phase_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      op_r    <= op_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== rtl/clbs_datapath.sv =====
// Datapath of the bus sequencer: configuration registers, hold time arithmetic
// and the output register. Depends on clbs_pkg.
module clbs_datapath import clbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  clbs_cmd_t         cmd,
  output clbs_stat_t        stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_reg_select,
  output logic              out_enable,
  output logic [7:0]        out_data_lines,
  output logic [HOLD_W-1:0] out_hold_us,
  output logic              out_last
);

  logic       eight_bit_r;
  logic [7:0] pulse_us_r;
  logic [7:0] cycle_us_r;
  logic [7:0] command_us_r;
  logic [3:0] slow_ms_r;
  logic [7:0] power_ms_r;

  logic              valid_r;
  logic              sel_r;
  logic              enable_r;
  logic [7:0]        data_r;
  logic [HOLD_W-1:0] hold_r;
  logic              last_r;

  logic [HOLD_W-1:0] power_hold;
  logic [13:0]       slow_hold;
  logic [12:0]       extra_hold;
  logic [HOLD_W-1:0] low_hold;
  logic [HOLD_W-1:0] hold_nxt;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eight_bit_r  <= 1'b0;
      pulse_us_r   <= 8'd1;
      cycle_us_r   <= 8'd1;
      command_us_r <= 8'd50;
      slow_ms_r    <= 4'd2;
      power_ms_r   <= 8'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EIGHT_BIT:  eight_bit_r  <= cfg_wdata[0];
        REG_PULSE_US:   pulse_us_r   <= cfg_wdata;
        REG_CYCLE_US:   cycle_us_r   <= cfg_wdata;
        REG_COMMAND_US: command_us_r <= cfg_wdata;
        REG_SLOW_MS:    slow_ms_r    <= cfg_wdata[3:0];
        REG_POWER_MS:   power_ms_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold time of the requested pin state.
  always_comb begin
    power_hold = HOLD_W'(power_ms_r) * HOLD_W'(US_PER_MS);
    slow_hold  = 14'(slow_ms_r) * 14'(US_PER_MS);
    case (cmd.extra)
      EXTRA_LONG:  extra_hold = WAIT_LONG_US;
      EXTRA_SHORT: extra_hold = WAIT_SHORT_US;
      default:     extra_hold = 13'd0;
    endcase
    low_hold = HOLD_W'(cycle_us_r)
             + (cmd.add_cmd ? HOLD_W'(command_us_r) : HOLD_W'(0))
             + HOLD_W'(extra_hold)
             + (cmd.slow ? HOLD_W'(slow_hold) : HOLD_W'(0));
    case (cmd.kind)
      KIND_POWER: hold_nxt = power_hold;
      KIND_HIGH:  hold_nxt = HOLD_W'(pulse_us_r);
      default:    hold_nxt = low_hold;
    endcase
  end

  assign stat.ready     = !valid_r || out_ready;
  assign stat.eight_bit = eight_bit_r;

  // Output register: loaded by the controller, emptied when the pin state is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sel_r    <= cmd.sel;
      enable_r <= (cmd.kind == KIND_HIGH);
      data_r   <= cmd.data;
      hold_r   <= hold_nxt;
      last_r   <= cmd.last;
    end
  end

  assign out_valid      = valid_r;
  assign out_reg_select = sel_r;
  assign out_enable     = enable_r;
  assign out_data_lines = data_r;
  assign out_hold_us    = hold_r;
  assign out_last       = last_r;

endmodule

// ===== rtl/clbs_checker.sv =====
// Port-level checks of the character display bus sequencer, bound to the top level.
// Depends on char_lcd_bus_sequencer_top.
module clbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // Reset leaves no pin state pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled pin state holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled pin state changed");

  // A request never ends with enable high.
  a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tlast)
    else $error("last pin state has enable high");

  // Enable high is followed at once by enable low on the same data.
  a_pulse_fall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata[0] |=>
      out_tvalid && !out_tdata[0] &&
      (out_tdata[8:1] == $past(out_tdata[8:1])))
    else $error("enable pulse not followed by its low state");

endmodule

bind char_lcd_bus_sequencer_top clbs_checker u_clbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
